FILE: sv/pid_position_incremental_top_macros.svh
// ----------------------------------------------------------------------------
// pid position/incremental assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_INCREMENTAL_TOP_MACROS_SVH
`define PID_POSITION_INCREMENTAL_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PPI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppi: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define PPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppi: next-cycle check failed");

`endif

FILE: sv/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// types and constants shared by the pid controller top level and datapath
// ----------------------------------------------------------------------------
package ppi_pkg;

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } mode_t;

  typedef enum logic {
    CMD_STEP  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KP        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KI        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KD        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PD_LIMIT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_I_LIMIT   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_LIMIT = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND = 3'd7;

  localparam logic [14:0] LIMIT_RESET = 15'h7fff;

  typedef struct packed {
    mode_t              mode;
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic        [14:0] pd_limit;
    logic        [14:0] i_limit;
    logic        [14:0] out_limit;
    logic        [15:0] dead_band;
  } ppi_cfg_t;

endpackage

FILE: sv/ppi_datapath.sv
// ----------------------------------------------------------------------------
// ppi_datapath
// one control step: error, gain products, clamps and next controller state
// ----------------------------------------------------------------------------
module ppi_datapath
  import ppi_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  ppi_cfg_t                  cfg,
  input  cmd_t                      cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] target,
  input  logic signed [SAMPLE_WIDTH-1:0] measured,
  input  logic signed [SAMPLE_WIDTH:0]   prev_err,
  input  logic signed [SAMPLE_WIDTH:0]   pprev_err,
  input  logic signed [15:0]             integ,
  input  logic signed [15:0]             held,
  output logic signed [SAMPLE_WIDTH:0]   prev_err_nxt,
  output logic signed [SAMPLE_WIDTH:0]   pprev_err_nxt,
  output logic signed [15:0]             integ_nxt,
  output logic signed [15:0]             held_nxt
);

  localparam int EW = SAMPLE_WIDTH + 1;   // error
  localparam int OW = SAMPLE_WIDTH + 3;   // widest operand (second difference)
  localparam int PW = OW + 16;            // gain product
  localparam int CW = PW + 1;             // clamp input, room for integral sum
  localparam int AW = (EW > 16) ? EW : 16;

  function automatic logic signed [15:0] clamp_sym(input logic signed [CW-1:0] v,
                                                   input logic [14:0] lim);
    logic signed [CW-1:0] lim_s;
    logic signed [15:0]   res;
    lim_s = signed'(CW'(lim));
    if (v > lim_s)       res = signed'({1'b0, lim});
    else if (v < -lim_s) res = -signed'({1'b0, lim});
    else                 res = v[15:0];
    return res;
  endfunction

  logic signed [EW-1:0] err;
  logic signed [OW-1:0] diff1, diff2, p_op, d_op;
  logic signed [PW-1:0] prod_p, prod_i, prod_d;
  logic signed [PW-1:0] sh_p, sh_i, sh_d;
  logic signed [CW-1:0] i_in;
  logic signed [15:0]   p_term, i_term, d_term, out_val;
  logic signed [17:0]   sum3, inc, upd;
  logic        [EW-1:0] abs_err;
  logic                 in_dead;

  assign err   = EW'(target) - EW'(measured);
  assign diff1 = OW'(err) - OW'(prev_err);
  assign diff2 = OW'(err) - (OW'(prev_err) <<< 1) + OW'(pprev_err);

  // positional uses e and e-prev, incremental uses the first and second differences
  assign p_op = (cfg.mode == MODE_POSITIONAL) ? OW'(err) : diff1;
  assign d_op = (cfg.mode == MODE_POSITIONAL) ? diff1 : diff2;

  assign prod_p = PW'(cfg.kp) * PW'(p_op);
  assign prod_i = PW'(cfg.ki) * PW'(err);
  assign prod_d = PW'(cfg.kd) * PW'(d_op);

  assign sh_p = prod_p >>> GAIN_FRAC_BITS;
  assign sh_i = prod_i >>> GAIN_FRAC_BITS;
  assign sh_d = prod_d >>> GAIN_FRAC_BITS;

  assign i_in = (cfg.mode == MODE_POSITIONAL) ? CW'(integ) + CW'(sh_i) : CW'(sh_i);

  assign p_term = clamp_sym(CW'(sh_p), cfg.pd_limit);
  assign i_term = clamp_sym(i_in, cfg.i_limit);
  assign d_term = clamp_sym(CW'(sh_d), cfg.pd_limit);

  assign sum3 = 18'(p_term) + 18'(i_term) + 18'(d_term);

  // most negative error wraps to the right unsigned magnitude
  assign abs_err = err[EW-1] ? EW'(-err) : EW'(err);
  assign in_dead = AW'(abs_err) < AW'(cfg.dead_band);

  assign inc = in_dead ? 18'sd0 : sum3;
  assign upd = (cfg.mode == MODE_POSITIONAL) ? sum3 : 18'(held) + inc;

  assign out_val = clamp_sym(CW'(upd), cfg.out_limit);

  always_comb begin
    prev_err_nxt  = prev_err;
    pprev_err_nxt = pprev_err;
    integ_nxt     = integ;
    held_nxt      = held;
    unique case (cmd)
      CMD_CLEAR: begin
        prev_err_nxt  = '0;
        pprev_err_nxt = '0;
        integ_nxt     = '0;
        held_nxt      = '0;
      end
      CMD_STEP: begin
        prev_err_nxt = err;
        integ_nxt    = i_term;
        held_nxt     = out_val;
        if (cfg.mode == MODE_INCREMENTAL) begin
          pprev_err_nxt = prev_err;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/pid_position_incremental_top.sv
// ----------------------------------------------------------------------------
// pid_position_incremental_top
// pid controller, positional or incremental form, on stream channels
// ----------------------------------------------------------------------------
// path: an input transaction enters the input register, then the control step
//   writes the result register and the controller state together
// throughput: one transaction per cycle unless output back-pressure stalls it
// reset: synchronous active low; clears stored state and pipeline valids,
//   loads register defaults (limits 32767, everything else zero)
`include "pid_position_incremental_top_macros.svh"

module pid_position_incremental_top
  import ppi_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // fields from bit 0: target, measured, zero padding
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      in_tdata,
  // fields from bit 0: cmd
  input  logic                                     in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // fields from bit 0: drive, zero padding
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        out_tdata,
  input  logic                                     cfg_we,
  input  logic [CFG_INDEX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                    cfg_wdata
);

  localparam int OUT_DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int XW     = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

  ppi_cfg_t cfg_r, cfg_nxt;

  logic                           s1_valid_r;
  cmd_t                           s1_cmd_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_target_r, s1_measured_r;
  logic                           out_valid_r;
  logic        [SAMPLE_WIDTH-1:0] drive_r;

  logic signed [SAMPLE_WIDTH:0]   prev_err_r, pprev_err_r, prev_err_nxt, pprev_err_nxt;
  logic signed [15:0]             integ_r, held_r, integ_nxt, held_nxt;
  logic signed [XW-1:0]           held_x;

  logic in_fire, s1_fire;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      cfg_nxt.mode      = mode_t'(cfg_wdata[0]);
        REG_KP:        cfg_nxt.kp        = signed'(cfg_wdata);
        REG_KI:        cfg_nxt.ki        = signed'(cfg_wdata);
        REG_KD:        cfg_nxt.kd        = signed'(cfg_wdata);
        REG_PD_LIMIT:  cfg_nxt.pd_limit  = cfg_wdata[14:0];
        REG_I_LIMIT:   cfg_nxt.i_limit   = cfg_wdata[14:0];
        REG_OUT_LIMIT: cfg_nxt.out_limit = cfg_wdata[14:0];
        REG_DEAD_BAND: cfg_nxt.dead_band = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_POSITIONAL;
      cfg_r.kp        <= '0;
      cfg_r.ki        <= '0;
      cfg_r.kd        <= '0;
      cfg_r.pd_limit  <= LIMIT_RESET;
      cfg_r.i_limit   <= LIMIT_RESET;
      cfg_r.out_limit <= LIMIT_RESET;
      cfg_r.dead_band <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // handshake: stage 1 moves on whenever the result register is free or draining
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r      <= cmd_t'(in_tuser);
      s1_target_r   <= signed'(in_tdata[SAMPLE_WIDTH-1:0]);
      s1_measured_r <= signed'(in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
    end
  end

  ppi_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .cfg           (cfg_r),
    .cmd           (s1_cmd_r),
    .target        (s1_target_r),
    .measured      (s1_measured_r),
    .prev_err      (prev_err_r),
    .pprev_err     (pprev_err_r),
    .integ         (integ_r),
    .held          (held_r),
    .prev_err_nxt  (prev_err_nxt),
    .pprev_err_nxt (pprev_err_nxt),
    .integ_nxt     (integ_nxt),
    .held_nxt      (held_nxt)
  );

  // drive is the held output, sign extended or truncated to the sample width
  assign held_x = XW'(held_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r  <= '0;
      pprev_err_r <= '0;
      integ_r     <= '0;
      held_r      <= '0;
    end else if (s1_fire) begin
      prev_err_r  <= prev_err_nxt;
      pprev_err_r <= pprev_err_nxt;
      integ_r     <= integ_nxt;
      held_r      <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      drive_r <= held_x[SAMPLE_WIDTH-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(drive_r);

  logic signed [XW-1:0] held_r_x;
  assign held_r_x = XW'(held_r);

  `PPI_ASSERT_NEXT(a_clear_gives_zero, s1_fire && (s1_cmd_r == CMD_CLEAR), drive_r == '0)
  `PPI_ASSERT_NEXT(a_drive_tracks_held, s1_fire, drive_r == held_r_x[SAMPLE_WIDTH-1:0])
  `PPI_ASSERT_NOW(a_stall_only_when_full, !in_tready, s1_valid_r && out_valid_r)
  `PPI_ASSERT_NEXT(a_positional_keeps_pprev,
                   s1_fire && (s1_cmd_r == CMD_STEP) && (cfg_r.mode == MODE_POSITIONAL),
                   $stable(pprev_err_r))

endmodule

FILE: verif/tb_pid_position_incremental_top.sv
// ----------------------------------------------------------------------------
// tb_pid_position_incremental_top
// self-checking bench: directed extremes then randomised phases under random
// register settings, idles on either, both or neither stream side, drive values
// predicted in the scoreboard and compared transaction by transaction
// ----------------------------------------------------------------------------
import ppi_pkg::*;

class pid_scoreboard;
  localparam int FRAC_BITS = 8;

  ppi_cfg_t           cfg;
  logic signed [16:0] last_err;
  logic signed [16:0] older_err;
  logic signed [15:0] integ;
  logic signed [15:0] held;
  logic        [15:0] drive_q[$];
  int errors;
  int checked;
  int clears;
  int pos_steps;
  int inc_steps;
  int settings;

  function new();
    cfg.mode      = MODE_POSITIONAL;
    cfg.kp        = '0;
    cfg.ki        = '0;
    cfg.kd        = '0;
    cfg.pd_limit  = LIMIT_RESET;
    cfg.i_limit   = LIMIT_RESET;
    cfg.out_limit = LIMIT_RESET;
    cfg.dead_band = '0;
    last_err      = '0;
    older_err     = '0;
    integ         = '0;
    held          = '0;
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MODE:      cfg.mode      = mode_t'(val[0]);
      REG_KP:        cfg.kp        = val;
      REG_KI:        cfg.ki        = val;
      REG_KD:        cfg.kd        = val;
      REG_PD_LIMIT:  cfg.pd_limit  = val[14:0];
      REG_I_LIMIT:   cfg.i_limit   = val[14:0];
      REG_OUT_LIMIT: cfg.out_limit = val[14:0];
      REG_DEAD_BAND: cfg.dead_band = val;
      default: ;
    endcase
  endfunction

  function longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // gain times operand, floor shift by the fraction bits
  function longint scale(logic signed [15:0] g, longint x);
    longint gl;
    gl = longint'(g);
    return (gl * x) >>> FRAC_BITS;
  endfunction

  function void note_input(cmd_t cmd, logic signed [15:0] tgt, logic signed [15:0] meas);
    longint e, p, i, d, inc, pdl, il, ol, last, older;
    if (cmd == CMD_CLEAR) begin
      last_err  = '0;
      older_err = '0;
      integ     = '0;
      held      = '0;
      clears++;
      drive_q.push_back('0);
      return;
    end
    e     = longint'(tgt) - longint'(meas);
    last  = longint'(last_err);
    older = longint'(older_err);
    pdl   = longint'(cfg.pd_limit);
    il    = longint'(cfg.i_limit);
    ol    = longint'(cfg.out_limit);
    if (cfg.mode == MODE_POSITIONAL) begin
      p     = clamp(scale(cfg.kp, e), pdl);
      i     = clamp(longint'(integ) + scale(cfg.ki, e), il);
      d     = clamp(scale(cfg.kd, e - last), pdl);
      integ = i[15:0];
      held  = 16'(clamp(p + i + d, ol));
      pos_steps++;
    end else begin
      p     = clamp(scale(cfg.kp, e - last), pdl);
      i     = clamp(scale(cfg.ki, e), il);
      d     = clamp(scale(cfg.kd, e - 2 * last + older), pdl);
      integ = i[15:0];
      inc   = p + i + d;
      if ((e < 0 ? -e : e) < longint'(cfg.dead_band)) inc = 0;
      held      = 16'(clamp(longint'(held) + inc, ol));
      older_err = last_err;
      inc_steps++;
    end
    last_err = e[16:0];
    drive_q.push_back(held);
  endfunction

  function void check_result(logic [15:0] got);
    logic [15:0] exp_drive;
    checked++;
    if (drive_q.size() == 0) begin
      errors++;
      $display("%0t drive with nothing outstanding: expected none, actual %0d",
               $time, $signed(got));
      return;
    end
    exp_drive = drive_q.pop_front();
    if (got !== exp_drive) begin
      errors++;
      $display("%0t drive mismatch: expected %0d, actual %0d",
               $time, $signed(exp_drive), $signed(got));
    end
  endfunction

  function int pending();
    return drive_q.size();
  endfunction
endclass

module tb_pid_position_incremental_top;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 60;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [31:0]            in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [15:0]            out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  pid_scoreboard sb = new();
  bit tx_idles;
  bit rx_idles;
  int hold_len;
  int quiet_cycles;

  pid_position_incremental_top #(
    .SAMPLE_WIDTH   (16),
    .GAIN_FRAC_BITS (8)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready)
        sb.note_input(cmd_t'(in_tuser), in_tdata[15:0], in_tdata[31:16]);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t no transaction for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin
    int gap;
    forever begin
      if (hold_len > 0) begin
        gap      = hold_len;
        hold_len = 0;
      end else begin
        gap = rx_idles ? $urandom_range(0, 10) : 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  function automatic ppi_cfg_t make_cfg(mode_t m, int kp, int ki, int kd,
                                        int pd, int il, int ol, int db);
    ppi_cfg_t c;
    c.mode      = m;
    c.kp        = 16'(kp);
    c.ki        = 16'(ki);
    c.kd        = 16'(kd);
    c.pd_limit  = 15'(pd);
    c.i_limit   = 15'(il);
    c.out_limit = 15'(ol);
    c.dead_band = 16'(db);
    return c;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 2047)) - 16'd1024;
      2:       return 16'($urandom_range(0, 511)) - 16'd256;
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  function automatic logic [14:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return LIMIT_RESET;
      1:       return '0;
      2:       return 15'($urandom);
      default: return 15'($urandom_range(1, 4000));
    endcase
  endfunction

  function automatic ppi_cfg_t pick_cfg();
    ppi_cfg_t c;
    c.mode      = mode_t'($urandom_range(0, 1));
    c.kp        = pick_gain();
    c.ki        = pick_gain();
    c.kd        = pick_gain();
    c.pd_limit  = pick_limit();
    c.i_limit   = pick_limit();
    c.out_limit = pick_limit();
    c.dead_band = $urandom_range(0, 1) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    return c;
  endfunction

  // unused upper bits of narrow registers carry random junk
  task automatic apply_config(input ppi_cfg_t c);
    logic [CFG_DATA_W-1:0] vals [8];
    vals[REG_MODE]      = {15'($urandom), 1'(c.mode)};
    vals[REG_KP]        = c.kp;
    vals[REG_KI]        = c.ki;
    vals[REG_KD]        = c.kd;
    vals[REG_PD_LIMIT]  = {1'($urandom), c.pd_limit};
    vals[REG_I_LIMIT]   = {1'($urandom), c.i_limit};
    vals[REG_OUT_LIMIT] = {1'($urandom), c.out_limit};
    vals[REG_DEAD_BAND] = c.dead_band;
    for (int r = 0; r < 8; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(r);
      cfg_wdata <= vals[r];
      @(posedge clk);
      sb.set_reg(CFG_INDEX_W'(r), vals[r]);
    end
    cfg_we <= 1'b0;
    sb.settings++;
  endtask

  task automatic send_item(input cmd_t cmd, input logic [15:0] tgt, input logic [15:0] meas);
    int gap;
    gap = tx_idles ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {meas, tgt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every drive value is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    cmd_t        cmd;
    logic [15:0] tgt;
    logic [15:0] meas;
    repeat (6) @(posedge clk);
    rst_n    <= 1'b1;
    tx_idles = 1'b1;
    rx_idles = 1'b1;

    // register defaults: all gains zero
    send_item(CMD_STEP, 16'd1234, 16'hffb3);
    send_item(CMD_STEP, 16'h7fff, 16'h8000);
    drain();

    // extreme gains, positional, full-scale errors both ways and a clear
    apply_config(make_cfg(MODE_POSITIONAL, 32767, -32768, 32767, 32767, 32767, 32767, 0));
    send_item(CMD_STEP, 16'h7fff, 16'h8000);
    send_item(CMD_STEP, 16'h8000, 16'h7fff);
    send_item(CMD_STEP, 16'h0000, 16'h0000);
    send_item(CMD_CLEAR, 16'h7fff, 16'h8000);
    send_item(CMD_STEP, 16'd100, 16'hfffb);
    drain();

    // incremental with dead zone: just below, exactly at, then far outside
    apply_config(make_cfg(MODE_INCREMENTAL, 256, 256, -32768, 1000, 500, 2000, 300));
    send_item(CMD_STEP, 16'd200, 16'd0);
    send_item(CMD_STEP, 16'd300, 16'd0);
    send_item(CMD_STEP, 16'h8000, 16'h7fff);
    send_item(CMD_STEP, 16'h7fff, 16'h8000);
    send_item(CMD_STEP, 16'h7fff, 16'h8000);
    send_item(CMD_CLEAR, 16'h1234, 16'h4321);
    send_item(CMD_STEP, 16'hffff, 16'h0000);
    drain();

    // zero limits in both forms
    apply_config(make_cfg(MODE_POSITIONAL, 256, 256, 256, 0, 0, 0, 0));
    send_item(CMD_STEP, 16'h7fff, 16'h8000);
    send_item(CMD_STEP, 16'h8000, 16'h0000);
    drain();
    apply_config(make_cfg(MODE_INCREMENTAL, -256, 512, 256, 0, 0, 0, 65535));
    send_item(CMD_STEP, 16'h7fff, 16'h8000);
    send_item(CMD_STEP, 16'h8000, 16'h7fff);
    drain();

    // alternating full-scale error drives the second difference to its extremes
    apply_config(make_cfg(MODE_INCREMENTAL, 32767, 32767, 32767, 32767, 32767, 32767, 0));
    send_item(CMD_STEP, 16'h7fff, 16'h8000);
    send_item(CMD_STEP, 16'h8000, 16'h7fff);
    send_item(CMD_STEP, 16'h7fff, 16'h8000);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      apply_config(pick_cfg());
      tx_idles = (ph % 4 == 0) || (ph % 4 == 3);
      rx_idles = (ph % 4 == 0) || (ph % 4 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender keeps offering through the hold so the pipeline backs up
        if (ph == 2 && n == 5) hold_len = LONG_HOLD;
        cmd  = ($urandom_range(0, 24) == 0) ? CMD_CLEAR : CMD_STEP;
        meas = 16'($urandom);
        case ($urandom_range(0, 3))
          0:       tgt = 16'($urandom);
          1:       tgt = meas + 16'($urandom_range(0, 255)) - 16'd128;
          2:       tgt = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          default: tgt = meas + 16'($urandom_range(0, 4095)) - 16'd2048;
        endcase
        send_item(cmd, tgt, meas);
      end
    end
    drain();

    $display("run: %0d transactions (%0d positional, %0d incremental, %0d clears), %0d checked",
             sb.pos_steps + sb.inc_steps + sb.clears, sb.pos_steps, sb.inc_steps,
             sb.clears, sb.checked);
    $display("run: %0d register settings, zero and full limits, long output hold",
             sb.settings);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
